// ===== rtl/tahi_pkg.sv =====
// shared types and constants for the angle history interpolator
package tahi_pkg;
  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned TimeW = 32;
  localparam int unsigned AngW = 16;
  localparam int unsigned EntW = TimeW + 2 * AngW;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [TimeW-1:0]  timestamp_us;
    logic signed [AngW-1:0] pan_in;
    logic signed [AngW-1:0] tilt_in;
  } req_t;

  typedef struct packed {
    logic signed [AngW-1:0] pan_out;
    logic signed [AngW-1:0] tilt_out;
    logic [TimeW-1:0]  gap_us;
    logic              result_valid;
    logic              extrapolated;
    logic [6:0]        fill_count;
  } res_t;
endpackage

// ===== rtl/tahi_if.sv =====
// valid/ready channel interfaces for requests and results
interface tahi_req_if (input logic clk);
  logic          valid;
  logic          ready;
  tahi_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tahi_res_if (input logic clk);
  logic          valid;
  logic          ready;
  tahi_pkg::res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/timestamped_angle_history_interpolator.sv =====
// Ring of up to 64 timestamped pan/tilt samples with time-interpolated lookup. Every request
// gives one result, and the block takes one request at a time: it is not ready again until the
// result has been taken. Push, clear and the unused code go from the accept straight to the
// result. A query that clamps to the oldest sample reads it and gives the result; one that
// clamps to the newest reads the oldest, then the newest. When it interpolates it runs:
// - the oldest and newest reads
// - up to six binary-search reads
// - two pair reads through the single ram port
// - a restoring division for the weight
// - two shift-add multiplies for pan and tilt
// The division and the multiplies run on one shared adder. A stalled result holds the block.
module timestamped_angle_history_interpolator (
  input logic clk,
  input logic rst_n,
  tahi_req_if.sink   in_req,
  tahi_res_if.source out_res
);
  localparam int unsigned IW = tahi_pkg::IdxW;
  localparam int unsigned CW = tahi_pkg::CntW;
  localparam int unsigned EW = tahi_pkg::EntW;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD_OLD = 4'd1, S_OLD = 4'd2, S_RD_NEW = 4'd3,
    S_NEW = 4'd4, S_SRCH = 4'd5, S_SRCH_W = 4'd6, S_RD_A = 4'd7, S_A = 4'd8,
    S_RD_B = 4'd9, S_B = 4'd10, S_DIV = 4'd11, S_MUL = 4'd12, S_OUT = 4'd13;

  logic [3:0]  st_r, st_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  tahi_pkg::req_t req_r;
  tahi_pkg::res_t res_r;
  logic        out_v_r;

  logic [CW-1:0] lo_r, hi_r;
  logic [31:0] ta_r, tb_r;
  logic [15:0] pa_r, ta_ang_r, pb_r, tlb_r;
  logic [31:0] num_r, span_r;
  logic [31:0] rem_r;
  logic [16:0] dn_r;
  logic [16:0] w_r;
  logic [4:0]  step_r;
  logic        ch_r;
  logic signed [34:0] acc_r;
  logic signed [16:0] d_r;

  logic          accept;
  logic          we;
  logic [IW-1:0] addr;
  logic [EW-1:0] rdata;
  logic [IW-1:0] base;
  logic [CW-1:0] mid;
  logic [31:0]   rt;
  logic [15:0]   rp, rtl;
  logic [48:0]   dvd;
  logic [4:0]    bsel;
  logic [34:0]   alu_a, alu_b, alu;
  logic          alu_cin;

  assign accept = in_req.valid && in_req.ready;
  assign base = head_r - cnt_r[IW-1:0];
  assign mid  = CW'((lo_r + hi_r) >> 1);
  assign {rt, rp, rtl} = rdata;
  assign we = accept && (in_req.payload.req_type == tahi_pkg::REQ_PUSH);

  always_comb begin
    case (st_r)
      S_IDLE:   addr = head_r;
      S_RD_OLD: addr = base;
      S_RD_NEW: addr = base + IW'(cnt_r - 1'b1);
      S_SRCH:   addr = base + mid[IW-1:0];
      S_RD_A:   addr = base + lo_r[IW-1:0];
      S_RD_B:   addr = base + hi_r[IW-1:0];
      default:  addr = base;
    endcase
  end

  tahi_ram #(.Width(EW), .Depth(tahi_pkg::Capacity)) u_ram (
    .clk, .we, .addr,
    .wdata({in_req.payload.timestamp_us, in_req.payload.pan_in, in_req.payload.tilt_in}),
    .rdata
  );

  assign in_req.ready  = (st_r == S_IDLE) && !out_v_r;
  assign out_res.valid = out_v_r;
  assign out_res.payload = res_r;

  // dividend num*65536 + span/2; quotient fits 17 bits so the top part is below span
  assign dvd  = {1'b0, num_r, 16'd0} + 49'(span_r >> 1);
  assign bsel = 5'd17 - step_r;

  // shared adder: divide trial subtract or multiply accumulate
  always_comb begin
    if (st_r == S_DIV) begin
      alu_a   = {2'b00, rem_r, dn_r[16]};
      alu_b   = ~{3'b000, span_r};
      alu_cin = 1'b1;
    end else begin
      alu_a   = acc_r;
      alu_b   = (bsel <= 5'd16 && w_r[bsel]) ? (35'(d_r) <<< bsel) : 35'd0;
      alu_cin = 1'b0;
    end
  end
  assign alu = alu_a + alu_b + 35'(alu_cin);

  function automatic logic [31:0] adiff(logic [31:0] x, logic [31:0] y);
    return (x >= y) ? x - y : y - x;
  endfunction

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (in_req.payload.req_type == tahi_pkg::REQ_PUSH) begin
        head_nxt = head_r + 1'b1;
        if (cnt_r != CW'(tahi_pkg::Capacity)) cnt_nxt = cnt_r + 1'b1;
      end else if (in_req.payload.req_type == tahi_pkg::REQ_CLEAR) begin
        head_nxt = '0;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; head_r <= '0; cnt_r <= '0; out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      if (st_r != S_OUT && st_nxt == S_OUT) out_v_r <= 1'b1;
      else if (out_res.valid && out_res.ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (accept) begin
        req_r <= in_req.payload;
        res_r <= {66'd0, 7'(cnt_nxt)};
      end
      S_OLD: begin
        lo_r <= '0; hi_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1) || req_r.timestamp_us <= rt) begin
          res_r.pan_out <= rp; res_r.tilt_out <= rtl; res_r.result_valid <= 1'b1;
          res_r.extrapolated <= 1'b1; res_r.gap_us <= adiff(req_r.timestamp_us, rt);
        end
      end
      S_NEW: if (req_r.timestamp_us >= rt) begin
        res_r.pan_out <= rp; res_r.tilt_out <= rtl; res_r.result_valid <= 1'b1;
        res_r.extrapolated <= 1'b1; res_r.gap_us <= adiff(req_r.timestamp_us, rt);
      end
      S_SRCH_W: if (rt <= req_r.timestamp_us) lo_r <= mid; else hi_r <= mid;
      S_A: begin ta_r <= rt; pa_r <= rp; ta_ang_r <= rtl; end
      S_B: begin
        tb_r <= rt; pb_r <= rp; tlb_r <= rtl;
        num_r <= req_r.timestamp_us - ta_r;
        span_r <= rt - ta_r;
        step_r <= '0;
        ch_r <= 1'b0;
        res_r.result_valid <= 1'b1;
        res_r.gap_us <= (adiff(req_r.timestamp_us, ta_r) < adiff(req_r.timestamp_us, rt))
          ? adiff(req_r.timestamp_us, ta_r) : adiff(req_r.timestamp_us, rt);
      end
      S_DIV: begin
        if (step_r == 5'd0) begin
          if (req_r.timestamp_us <= ta_r || tb_r <= ta_r) begin
            w_r <= '0; step_r <= 5'd18;
          end else if (req_r.timestamp_us >= tb_r) begin
            w_r <= 17'h10000; step_r <= 5'd18;
          end else begin
            rem_r <= dvd[48:17]; dn_r <= dvd[16:0]; w_r <= '0; step_r <= 5'd1;
          end
        end else if (step_r <= 5'd17) begin
          // restoring division, one quotient bit per step
          if (!alu[34]) begin
            rem_r <= alu[31:0]; w_r <= {w_r[15:0], 1'b1};
          end else begin
            rem_r <= {rem_r[30:0], dn_r[16]}; w_r <= {w_r[15:0], 1'b0};
          end
          dn_r <= {dn_r[15:0], 1'b0};
          step_r <= step_r + 1'b1;
        end else begin
          step_r <= '0;
        end
      end
      S_MUL: begin
        if (step_r == 5'd0) begin
          acc_r <= 35'sd32768;
          d_r <= ch_r ? (17'(signed'(tlb_r)) - 17'(signed'(ta_ang_r)))
                      : (17'(signed'(pb_r)) - 17'(signed'(pa_r)));
          step_r <= 5'd1;
        end else if (step_r <= 5'd17) begin
          acc_r <= alu; step_r <= step_r + 1'b1;
        end else begin
          if (!ch_r) res_r.pan_out <= pa_r + 16'(acc_r >>> 16);
          else res_r.tilt_out <= ta_ang_r + 16'(acc_r >>> 16);
          ch_r <= ~ch_r; step_r <= '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (accept) begin
        if (in_req.payload.req_type == tahi_pkg::REQ_QUERY && cnt_r != '0) st_nxt = S_RD_OLD;
        else st_nxt = S_OUT;
      end
      S_RD_OLD: st_nxt = S_OLD;
      S_OLD: st_nxt = (cnt_r == CW'(1) || req_r.timestamp_us <= rt) ? S_OUT : S_RD_NEW;
      S_RD_NEW: st_nxt = S_NEW;
      S_NEW: st_nxt = (req_r.timestamp_us >= rt) ? S_OUT : S_SRCH;
      S_SRCH: st_nxt = (hi_r - lo_r > CW'(1)) ? S_SRCH_W : S_RD_A;
      S_SRCH_W: st_nxt = S_SRCH;
      S_RD_A: st_nxt = S_A;
      S_A: st_nxt = S_RD_B;
      S_RD_B: st_nxt = S_B;
      S_B: st_nxt = S_DIV;
      S_DIV: st_nxt = (step_r == 5'd18) ? S_MUL : S_DIV;
      S_MUL: st_nxt = (step_r == 5'd18 && ch_r) ? S_OUT : S_MUL;
      S_OUT: st_nxt = out_res.ready ? S_IDLE : S_OUT;
      default: st_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/tahi_ram.sv =====
// generic single port ram with registered read
module tahi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/tahi_checker.sv =====
// port-level checks for the angle history interpolator
module tahi_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input tahi_pkg::res_t res
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res))
    else $error("result changed while stalled");
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !res.result_valid |-> res.pan_out == '0 && res.tilt_out == '0
    && res.gap_us == '0 && !res.extrapolated) else $error("invalid result not zero");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> res.fill_count <= 7'(tahi_pkg::Capacity)) else $error("fill too large");
endmodule

bind timestamped_angle_history_interpolator tahi_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_res.valid), .out_ready(out_res.ready),
  .res(out_res.payload)
);
